### rtl/core/u8u16_pkg.sv
// shared types and constants of the utf-8 to utf-16 transcoder
package u8u16_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] LEAD_6 = 8'hFC;
	localparam logic [7:0] LEAD_5 = 8'hF8;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] CONT_LO = 8'h80;

	localparam logic [30:0] SURR_LO   = 31'h0000D800;
	localparam logic [30:0] SURR_HI   = 31'h0000E000;
	localparam logic [30:0] PLANE1    = 31'h00010000;
	localparam logic [30:0] CP_LIMIT  = 31'h00110000;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_LEAD = 3'd1,
		ST_TRUNC    = 3'd2,
		ST_SURR     = 3'd3,
		ST_RANGE    = 3'd4
	} status_t;

	typedef struct packed {
		logic [15:0] code_unit;
		status_t     status;
		logic        last_of_run;
	} result_t;

	// results produced by one decoded byte
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} dec_out_t;

endpackage

### rtl/core/u8u16_byte_if.sv
// byte channel interface
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

### rtl/core/u8u16_unit_if.sv
// code unit channel interface
interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic [2:0]  status;
	logic        last_of_run;

	modport source (output valid, output code_unit, output status, output last_of_run,
		input ready);
	modport sink   (input valid, input code_unit, input status, input last_of_run,
		output ready);
endinterface

### rtl/core/u8u16_decoder.sv
// sequence state and per-byte decode into zero, one or two code units
module u8u16_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          in_byte,
	input  logic                end_of_string,
	output u8u16_pkg::dec_out_t dec
);

	logic [2:0]  pending_q;
	logic [30:0] partial_q;
	logic [2:0]  pending_d;
	logic [30:0] partial_d;
	logic [30:0] cp;
	logic [20:0] cp_off;
	logic [2:0]  lead_cnt;
	logic [30:0] lead_val;

	assign cp     = {partial_q[24:0], in_byte[5:0]};
	assign cp_off = cp[20:0] - u8u16_pkg::PLANE1[20:0];

	always_comb begin
		lead_cnt = 3'd0;
		lead_val = '0;
		if (in_byte >= u8u16_pkg::LEAD_6) begin
			lead_cnt = 3'd5;
			lead_val = {30'd0, in_byte[0]};
		end else if (in_byte >= u8u16_pkg::LEAD_5) begin
			lead_cnt = 3'd4;
			lead_val = {29'd0, in_byte[1:0]};
		end else if (in_byte >= u8u16_pkg::LEAD_4) begin
			lead_cnt = 3'd3;
			lead_val = {28'd0, in_byte[2:0]};
		end else if (in_byte >= u8u16_pkg::LEAD_3) begin
			lead_cnt = 3'd2;
			lead_val = {27'd0, in_byte[3:0]};
		end else if (in_byte >= u8u16_pkg::LEAD_2) begin
			lead_cnt = 3'd1;
			lead_val = {26'd0, in_byte[4:0]};
		end
	end

	always_comb begin
		dec       = '0;
		pending_d = 3'd0;
		partial_d = '0;
		dec.first.status  = u8u16_pkg::ST_OK;
		dec.second.status = u8u16_pkg::ST_OK;
		dec.first.last_of_run  = 1'b1;
		dec.second.last_of_run = 1'b1;
		if (pending_q == 3'd0) begin
			if (lead_cnt != 3'd0) begin
				if (end_of_string) begin
					dec.count        = 2'd1;
					dec.first.status = u8u16_pkg::ST_TRUNC;
				end else begin
					pending_d = lead_cnt;
					partial_d = lead_val;
				end
			end else if (in_byte >= u8u16_pkg::CONT_LO) begin
				dec.count        = 2'd1;
				dec.first.status = u8u16_pkg::ST_BAD_LEAD;
			end else begin
				dec.count           = 2'd1;
				dec.first.code_unit = {8'd0, in_byte};
			end
		end else if (pending_q == 3'd1) begin
			// sequence completes on this byte
			dec.count = 2'd1;
			if (cp < u8u16_pkg::PLANE1) begin
				if (cp >= u8u16_pkg::SURR_LO && cp < u8u16_pkg::SURR_HI) begin
					dec.first.status = u8u16_pkg::ST_SURR;
				end else begin
					dec.first.code_unit = cp[15:0];
				end
			end else if (cp < u8u16_pkg::CP_LIMIT) begin
				dec.count               = 2'd2;
				dec.first.code_unit     = u8u16_pkg::HI_SURR | {6'd0, cp_off[19:10]};
				dec.first.last_of_run   = 1'b0;
				dec.second.code_unit    = u8u16_pkg::LO_SURR | {6'd0, cp_off[9:0]};
			end else begin
				dec.first.status = u8u16_pkg::ST_RANGE;
			end
		end else if (end_of_string) begin
			dec.count        = 2'd1;
			dec.first.status = u8u16_pkg::ST_TRUNC;
		end else begin
			pending_d = pending_q - 3'd1;
			partial_d = cp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
			partial_q <= '0;
		end else if (fire) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
		end
	end

`ifndef ASSERT_OFF
	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd5)
		else $error("pending count beyond five");
	a_result_ends_seq: assert property (@(posedge clk) disable iff (!arst_n)
		fire && dec.count != 2'd0 |=> pending_q == 3'd0)
		else $error("sequence still open after a result");
	a_pair_ok: assert property (@(posedge clk) disable iff (!arst_n)
		dec.count == 2'd2 |-> dec.first.status == u8u16_pkg::ST_OK
			&& dec.second.status == u8u16_pkg::ST_OK && !dec.first.last_of_run)
		else $error("malformed surrogate pair");
`endif

endmodule

### rtl/core/u8u16_out_fifo.sv
// small result queue taking up to two beats a cycle and giving one while the receiver is ready
module u8u16_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  u8u16_pkg::dec_out_t push,
	output logic                room,
	u8u16_unit_if.source        units
);

	u8u16_pkg::result_t              mem_q [u8u16_pkg::FIFO_DEPTH];
	logic [u8u16_pkg::PTR_W-1:0]     wr_ptr_q;
	logic [u8u16_pkg::PTR_W-1:0]     rd_ptr_q;
	logic [u8u16_pkg::CNT_W-1:0]     count_q;
	logic                            pop;
	logic [u8u16_pkg::PTR_W-1:0]     wr_ptr_p1;

	assign pop       = units.valid && units.ready;
	assign wr_ptr_p1 = wr_ptr_q + u8u16_pkg::PTR_W'(1);
	// space for a worst-case pair
	assign room      = count_q <= u8u16_pkg::CNT_W'(u8u16_pkg::FIFO_DEPTH - 2);

	assign units.valid       = count_q != '0;
	assign units.code_unit   = mem_q[rd_ptr_q].code_unit;
	assign units.status      = mem_q[rd_ptr_q].status;
	assign units.last_of_run = mem_q[rd_ptr_q].last_of_run;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + u8u16_pkg::PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + u8u16_pkg::PTR_W'(1);
			end
			count_q <= count_q + u8u16_pkg::CNT_W'(push.count)
				- u8u16_pkg::CNT_W'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= u8u16_pkg::CNT_W'(u8u16_pkg::FIFO_DEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> (count_q + u8u16_pkg::CNT_W'(push.count))
			<= u8u16_pkg::CNT_W'(u8u16_pkg::FIFO_DEPTH))
		else $error("queue overflow");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pop && push.count == 2'd0 |=> $stable(count_q) && $stable(rd_ptr_q))
		else $error("queue moved without a beat");
`endif

endmodule

### rtl/core/utf8_to_utf16_transcoder_top.sv
// top level of the utf-8 to utf-16 transcoder
//
// takes one utf-8 byte per beat on bytes_ch, with end_of_string on the final
// byte of a string, and gives utf-16 code units on units_ch. a rate of one
// byte per cycle is held while the queue has room for a pair: a byte is
// registered in the input stage, then decoded combinationally against the
// sequence state, and its zero, one or two results go into a four-entry result
// queue that gives one beat per cycle while units_ch is ready. the input stage
// moves on whenever the queue has room for a pair, so bytes keep flowing while
// earlier results wait to be taken. lead bytes 0xc0-0xff open sequences of one
// to five continuation bytes (legacy 5- and 6-byte forms included); code points
// from 0x10000 to 0x10ffff give a surrogate pair with last_of_run on the low
// half. errors (stray continuation byte, truncated string, surrogate code
// point, value of 0x110000 or more) give one beat with code_unit zero and the
// status code, and drop the sequence.
module utf8_to_utf16_transcoder_top (
	input  logic         clk,
	input  logic         arst_n,
	u8u16_byte_if.sink   bytes_ch,
	u8u16_unit_if.source units_ch
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;

	// decode and queue handshake
	logic                room;
	logic                fire;
	u8u16_pkg::dec_out_t dec;
	u8u16_pkg::dec_out_t push;

	// a registered byte is decoded when the queue can take a pair
	assign fire           = valid_s1 && room;
	assign bytes_ch.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes_ch.ready) begin
			valid_s1 <= bytes_ch.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (bytes_ch.valid && bytes_ch.ready) begin
			byte_s1 <= bytes_ch.in_byte;
			eos_s1  <= bytes_ch.end_of_string;
		end
	end

	u8u16_decoder u_decoder (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.in_byte       (byte_s1),
		.end_of_string (eos_s1),
		.dec           (dec)
	);

	// only a decoded byte pushes results
	always_comb begin
		push = dec;
		if (!fire) begin
			push.count = 2'd0;
		end
	end

	u8u16_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.units  (units_ch)
	);

`ifndef ASSERT_OFF
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(byte_s1) && $stable(eos_s1))
		else $error("stalled byte lost");
	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> push.count == 2'd0)
		else $error("results without a byte");
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> bytes_ch.ready)
		else $error("empty input stage not ready");
`endif

endmodule

### bench/tb.sv
// self-checking testbench for the utf-8 to utf-16 transcoder top level
module tb;

	typedef logic [7:0] octet_q_t[$];

	// receiver hold-off long enough to fill the result queue and stall the byte input
	localparam int unsigned HOLD_CYCLES = 240;
	// cycles allowed for results to come back once the sender has stopped
	localparam int unsigned DRAIN_LIMIT = 50000;

	// directed opening: {end_of_string, byte}
	localparam logic [8:0] DIRECTED [26] = '{
		// plain ascii, lowest and highest
		{1'b0, 8'h00}, {1'b1, 8'h7F},
		// stray continuation bytes in lead position
		{1'b0, 8'h80}, {1'b1, 8'hBF},
		// two-byte form whose continuation carries an 11 prefix (not checked)
		{1'b0, 8'hC3}, {1'b1, 8'hE9},
		// four-byte form giving a surrogate pair
		{1'b0, 8'hF0}, {1'b0, 8'h9F}, {1'b0, 8'h98}, {1'b1, 8'h80},
		// first value past the unicode range
		{1'b0, 8'hF4}, {1'b0, 8'h90}, {1'b0, 8'h80}, {1'b1, 8'h80},
		// encoded surrogate code point
		{1'b0, 8'hED}, {1'b0, 8'hA0}, {1'b1, 8'h80},
		// string ending mid-sequence, on a continuation and on a lead byte
		{1'b0, 8'hE2}, {1'b1, 8'h82},
		{1'b1, 8'hC3},
		// legacy six-byte form, overlong but accepted
		{1'b0, 8'hFC}, {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h80}, {1'b0, 8'h80},
		{1'b1, 8'h81}
	};

	// predicts the unit beats from the accepted byte beats and checks them in order
	class unit_scoreboard;
		u8u16_pkg::result_t due_q[$];
		logic [2:0]  seq_left;
		logic [30:0] cp_acc;
		int unsigned fails;
		int unsigned units_seen;
		int unsigned pairs_seen;
		int unsigned errors_seen;

		function new();
			seq_left    = '0;
			cp_acc      = '0;
			fails       = 0;
			units_seen  = 0;
			pairs_seen  = 0;
			errors_seen = 0;
		endfunction

		function void push_unit(logic [15:0] cu, u8u16_pkg::status_t st, logic last);
			u8u16_pkg::result_t r;
			r.code_unit   = cu;
			r.status      = st;
			r.last_of_run = last;
			due_q = {due_q, r};
		endfunction

		// any error drops the sequence in progress
		function void push_error(u8u16_pkg::status_t st);
			seq_left = '0;
			cp_acc   = '0;
			push_unit(16'h0000, st, 1'b1);
		endfunction

		function void finish_cp(logic [30:0] cp);
			logic [30:0] off;
			seq_left = '0;
			cp_acc   = '0;
			if (cp < u8u16_pkg::PLANE1) begin
				if (cp >= u8u16_pkg::SURR_LO && cp < u8u16_pkg::SURR_HI)
					push_error(u8u16_pkg::ST_SURR);
				else
					push_unit(cp[15:0], u8u16_pkg::ST_OK, 1'b1);
			end else if (cp < u8u16_pkg::CP_LIMIT) begin
				off = cp - u8u16_pkg::PLANE1;
				push_unit(u8u16_pkg::HI_SURR | {6'd0, off[19:10]}, u8u16_pkg::ST_OK, 1'b0);
				push_unit(u8u16_pkg::LO_SURR | {6'd0, off[9:0]}, u8u16_pkg::ST_OK, 1'b1);
			end else begin
				push_error(u8u16_pkg::ST_RANGE);
			end
		endfunction

		function void note_byte(logic [7:0] b, logic eos);
			logic [2:0]  need;
			logic [30:0] lead_bits;
			if (seq_left == 3'd0) begin
				if (b >= u8u16_pkg::LEAD_6) begin
					need      = 3'd5;
					lead_bits = {30'd0, b[0]};
				end else if (b >= u8u16_pkg::LEAD_5) begin
					need      = 3'd4;
					lead_bits = {29'd0, b[1:0]};
				end else if (b >= u8u16_pkg::LEAD_4) begin
					need      = 3'd3;
					lead_bits = {28'd0, b[2:0]};
				end else if (b >= u8u16_pkg::LEAD_3) begin
					need      = 3'd2;
					lead_bits = {27'd0, b[3:0]};
				end else if (b >= u8u16_pkg::LEAD_2) begin
					need      = 3'd1;
					lead_bits = {26'd0, b[4:0]};
				end else if (b >= u8u16_pkg::CONT_LO) begin
					push_error(u8u16_pkg::ST_BAD_LEAD);
					return;
				end else begin
					push_unit({8'h00, b}, u8u16_pkg::ST_OK, 1'b1);
					return;
				end
				if (eos) begin
					push_error(u8u16_pkg::ST_TRUNC);
				end else begin
					seq_left = need;
					cp_acc   = lead_bits;
				end
			end else begin
				cp_acc   = {cp_acc[24:0], b[5:0]};
				seq_left = seq_left - 3'd1;
				if (seq_left == 3'd0)
					finish_cp(cp_acc);
				else if (eos)
					push_error(u8u16_pkg::ST_TRUNC);
			end
		endfunction

		function void check_unit(logic [15:0] cu, logic [2:0] st, logic last);
			u8u16_pkg::result_t want;
			units_seen++;
			if (due_q.size() == 0) begin
				$error("unexpected unit beat: code_unit %h status %0d last_of_run %b",
					cu, st, last);
				fails++;
				return;
			end
			want = due_q.pop_front();
			if (want.status == u8u16_pkg::ST_OK && !want.last_of_run)
				pairs_seen++;
			if (want.status != u8u16_pkg::ST_OK)
				errors_seen++;
			if (cu !== want.code_unit) begin
				$error("code_unit: expected %h, got %h", want.code_unit, cu);
				fails++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				fails++;
			end
			if (last !== want.last_of_run) begin
				$error("last_of_run: expected %b, got %b", want.last_of_run, last);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	u8u16_byte_if bytes_ch();
	u8u16_unit_if units_ch();

	unit_scoreboard sb;

	// idling odds in percent, changed by phase
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	int unsigned bytes_sent;
	bit          hold_req;

	utf8_to_utf16_transcoder_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes_ch (bytes_ch),
		.units_ch (units_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one beat on the byte channel, with random idle cycles in front of it
	task automatic send_byte(input logic [7:0] b, input logic eos);
		while ($urandom_range(99) < src_idle_pct) begin
			bytes_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_ch.valid         <= 1'b1;
		bytes_ch.in_byte       <= b;
		bytes_ch.end_of_string <= eos;
		@(posedge clk);
		while (!bytes_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// the string ends at index cut, anything after it is dropped
	task automatic send_text(input octet_q_t txt, input int cut);
		for (int i = 0; i <= cut; i++)
			send_byte(txt[i], i == cut);
	endtask

	// sender stops and waits for every predicted beat to come back
	task automatic wait_drained();
		int unsigned guard;
		guard = 0;
		bytes_ch.valid <= 1'b0;
		while (sb.due_q.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// one complete character sequence of random length and content
	function automatic octet_q_t random_char();
		octet_q_t    q;
		int unsigned w;
		int          n;
		logic [30:0] cp;
		logic [7:0]  cb;
		w = $urandom_range(99);
		n = (w < 30) ? 1 : (w < 45) ? 2 : (w < 65) ? 3 : (w < 85) ? 4 : (w < 92) ? 5 : 6;
		case (n)
			1: begin
				cp = $urandom_range(8'h7F);
				q = {q, {1'b0, cp[6:0]}};
			end
			2: begin
				cp = $urandom_range(11'h7FF);
				q = {q, u8u16_pkg::LEAD_2 | {3'd0, cp[10:6]}};
			end
			3: begin
				// a quarter land in the surrogate block
				if ($urandom_range(3) == 0)
					cp = $urandom_range(16'hDFFF, 16'hD800);
				else
					cp = $urandom_range(16'hFFFF);
				q = {q, u8u16_pkg::LEAD_3 | {4'd0, cp[15:12]}};
			end
			4: begin
				w = $urandom_range(3);
				if (w == 0)
					cp = $urandom_range(21'h1100FF, 21'h10FF00);
				else if (w == 3)
					cp = $urandom_range(21'h1FFFFF);
				else
					cp = $urandom_range(21'h10FFFF, 21'h10000);
				q = {q, u8u16_pkg::LEAD_4 | {5'd0, cp[20:18]}};
			end
			5: begin
				if ($urandom_range(1) == 0)
					cp = $urandom_range(26'h3FFFFFF);
				else
					cp = $urandom_range(21'h10FFFF);
				q = {q, u8u16_pkg::LEAD_5 | {6'd0, cp[25:24]}};
			end
			default: begin
				// leads 0xfc-0xff all open a six-byte form
				if ($urandom_range(1) == 0)
					cp = $urandom_range(31'h7FFFFFFF);
				else
					cp = $urandom_range(21'h10FFFF);
				q = {q, u8u16_pkg::LEAD_6 | {6'd0, 1'($urandom_range(1)), cp[30]}};
			end
		endcase
		for (int i = n - 2; i >= 0; i--) begin
			cb = u8u16_pkg::CONT_LO | {2'b00, cp[6*i +: 6]};
			// the continuation prefix is not checked, so vary it now and then
			if ($urandom_range(15) == 0)
				cb[7:6] = 2'($urandom_range(3));
			q = {q, cb};
		end
		return q;
	endfunction

	// mostly well-formed strings, some cut short, some plain noise
	task automatic send_random_string();
		octet_q_t    txt;
		octet_q_t    one;
		int unsigned pick;
		int          cut;
		int          len;
		pick = $urandom_range(99);
		if (pick < 12) begin
			len = $urandom_range(6, 1);
			repeat (len)
				txt = {txt, 8'($urandom_range(255))};
			cut = len - 1;
		end else begin
			repeat ($urandom_range(5, 1)) begin
				one = random_char();
				foreach (one[i])
					txt = {txt, one[i]};
			end
			cut = (pick < 27) ? $urandom_range(txt.size() - 1) : txt.size() - 1;
		end
		send_text(txt, cut);
	endtask

	// receiver: random ready, plus one long hold-off counted here
	initial begin
		units_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				units_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_req = 1'b0;
			end
			units_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// both channels are sampled at the edge, before any update of that edge lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (bytes_ch.valid && bytes_ch.ready)
				sb.note_byte(bytes_ch.in_byte, bytes_ch.end_of_string);
			if (units_ch.valid && units_ch.ready)
				sb.check_unit(units_ch.code_unit, units_ch.status, units_ch.last_of_run);
		end
	end

	initial begin
		sb                     = new();
		arst_n                 = 1'b0;
		bytes_ch.valid         = 1'b0;
		bytes_ch.in_byte       = 8'h00;
		bytes_ch.end_of_string = 1'b0;
		src_idle_pct           = 26;
		snk_idle_pct           = 57;
		bytes_sent             = 0;
		hold_req               = 1'b0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed opening under the first idling pattern
		foreach (DIRECTED[i])
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
		wait_drained();

		// sender idles more rarely than the receiver
		while (bytes_sent < 320)
			send_random_string();
		wait_drained();

		// roles swapped
		src_idle_pct = 57;
		snk_idle_pct = 26;
		while (bytes_sent < 620)
			send_random_string();
		wait_drained();

		// full rate, opening with the long receiver hold-off so the queue backs up
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_req     = 1'b1;
		while (bytes_sent < 920)
			send_random_string();

		wait_drained();
		// time for the input stage and the result queue to empty, with margin
		repeat (16)
			@(posedge clk);

		if (sb.due_q.size() != 0) begin
			$error("%0d expected unit beats never arrived", sb.due_q.size());
			sb.fails++;
		end
		$display("run covered %0d byte beats under three idling patterns and a long hold-off",
			bytes_sent);
		$display("%0d unit beats checked: %0d surrogate pairs, %0d error beats",
			sb.units_seen, sb.pairs_seen, sb.errors_seen);
		if (sb.fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### utf8_to_utf16_transcoder_top.f
rtl/core/u8u16_pkg.sv
rtl/core/u8u16_byte_if.sv
rtl/core/u8u16_unit_if.sv
rtl/core/u8u16_decoder.sv
rtl/core/u8u16_out_fifo.sv
rtl/core/utf8_to_utf16_transcoder_top.sv
bench/tb.sv
